// ===== sv/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

    // default sizes, overridable on the top level
    localparam int MACHINES_DEF  = 16;
    localparam int TIME_BITS_DEF = 48;

    // fixed field widths of the channels
    localparam int MIDX_BITS = 4;
    localparam int LEN_BITS  = 32;
    localparam int OUT_BITS  = 48;

    typedef struct packed {
        logic                 new_job;
        logic                 task_start;
        logic                 job_end;
        logic [MIDX_BITS-1:0] machine_index;
        logic [LEN_BITS-1:0]  step_length;
    } sst_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] start_at;
        logic [OUT_BITS-1:0] finish_time;
        logic [OUT_BITS-1:0] makespan;
        logic                last;
    } sst_out_t;

    // control of the step calculation
    typedef struct packed {
        logic new_job;
        logic task_start;
        logic in_range;
        logic entry_valid;
        logic fwd_hit;
    } sst_ctl_t;

endpackage

`default_nettype wire

// ===== sv/sst_time_ram.sv =====
`default_nettype none

module sst_time_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 48
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/sst_step_calc.sv =====
`default_nettype none

module sst_step_calc #(
    parameter int TIME_BITS = 48
) (
    input  sst_pkg::sst_ctl_t                ctl,
    input  logic [TIME_BITS-1:0]             rd_data,
    input  logic [TIME_BITS-1:0]             prev_finish,
    input  logic [TIME_BITS-1:0]             span,
    input  logic [sst_pkg::LEN_BITS-1:0]     step_length,
    output logic [TIME_BITS-1:0]             start_at,
    output logic [TIME_BITS-1:0]             finish_time,
    output logic [TIME_BITS-1:0]             span_next
);

    import sst_pkg::*;

    localparam int SUM_BITS = ((TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIME_BITS-1:0] free_at;
    logic [TIME_BITS-1:0] prev_eff;
    logic [TIME_BITS-1:0] span_eff;
    logic [SUM_BITS-1:0]  sum;

    always_comb
    begin
        // a new job sees every machine free at zero
        if (!ctl.new_job && ctl.in_range && ctl.entry_valid)
        begin
            // previous item wrote this entry in the cycle of our read
            free_at = ctl.fwd_hit ? prev_finish : rd_data;
        end
        else
        begin
            free_at = '0;
        end

        prev_eff = ctl.new_job ? '0 : prev_finish;
        span_eff = ctl.new_job ? '0 : span;

        if (!ctl.task_start && (prev_eff > free_at))
        begin
            start_at = prev_eff;
        end
        else
        begin
            start_at = free_at;
        end

        sum = SUM_BITS'(start_at) + SUM_BITS'(step_length);
        if (sum > SUM_BITS'(TMAX))
        begin
            finish_time = TMAX;
        end
        else
        begin
            finish_time = sum[TIME_BITS-1:0];
        end

        span_next = (finish_time > span_eff) ? finish_time : span_eff;
    end

endmodule

`default_nettype wire

// ===== sv/shop_schedule_timeline_top.sv =====
`default_nettype none
// channel | valid      | stall      | payload          | direction
// step    | step_valid | step_stall | step (sst_in_t)  | into the block
// res     | res_valid  | res_stall  | res (sst_out_t)  | out of the block
//
// one item per cycle sustained while the result side does not stall; an
// accepted item is read from the machine time memory into the calculation
// stage, which then writes the memory back and loads the result register
// when it advances
// reset clears the pipeline valid flags, the machine valid bits, the
// previous finish and the makespan at once; no clearing pass is needed
// a stalled result holds the pipeline and the step channel is stalled only
// when the calculation stage cannot hand its item on

module shop_schedule_timeline_top #(
    parameter int MACHINES  = sst_pkg::MACHINES_DEF,
    parameter int TIME_BITS = sst_pkg::TIME_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_valid,
    output logic              step_stall,
    input  sst_pkg::sst_in_t  step,
    output logic              res_valid,
    input  logic              res_stall,
    output sst_pkg::sst_out_t res
);

    import sst_pkg::*;

    localparam int AW = (MACHINES > 1) ? $clog2(MACHINES) : 1;

    // calculation stage
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    sst_in_t              s1_item_reg;
    logic                 s1_range_reg;
    logic                 s1_hit_reg;

    // job state kept in flip-flops
    logic [MACHINES-1:0]  mvalid_reg;
    logic [MACHINES-1:0]  mvalid_next;
    logic [TIME_BITS-1:0] prev_reg;
    logic [TIME_BITS-1:0] span_reg;

    // result register
    logic                 res_valid_reg;
    logic                 res_valid_next;
    sst_out_t             res_reg;

    logic                 accept;
    logic                 adv;
    logic                 in_range;
    logic [AW-1:0]        in_addr;
    logic [AW-1:0]        s1_addr;
    logic [TIME_BITS-1:0] rd_data;
    sst_ctl_t             ctl;
    logic [TIME_BITS-1:0] start_at;
    logic [TIME_BITS-1:0] finish_time;
    logic [TIME_BITS-1:0] span_next;

    // handshake: the calculation stage moves on when the result register
    // is empty or being taken
    assign adv        = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign step_stall = s1_valid_reg && !adv;
    assign accept     = step_valid && !step_stall;

    assign in_range = (32'(step.machine_index) < MACHINES);
    assign in_addr  = AW'(step.machine_index);
    assign s1_addr  = AW'(s1_item_reg.machine_index);

    // machine free times; read on acceptance, written back when the item leaves the calculation stage
    sst_time_ram #(
        .DEPTH (MACHINES),
        .AW    (AW),
        .DW    (TIME_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (adv && s1_range_reg),
        .wr_addr (s1_addr),
        .wr_data (finish_time),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    // the valid bits are current when the item is calculated, so a new job
    // or a write by the item just ahead is already seen there
    always_comb
    begin
        ctl.new_job     = s1_item_reg.new_job;
        ctl.task_start  = s1_item_reg.task_start;
        ctl.in_range    = s1_range_reg;
        ctl.entry_valid = s1_range_reg && mvalid_reg[s1_addr];
        ctl.fwd_hit     = s1_hit_reg;
    end

    sst_step_calc #(
        .TIME_BITS (TIME_BITS)
    ) u_calc (
        .ctl         (ctl),
        .rd_data     (rd_data),
        .prev_finish (prev_reg),
        .span        (span_reg),
        .step_length (s1_item_reg.step_length),
        .start_at    (start_at),
        .finish_time (finish_time),
        .span_next   (span_next)
    );

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        res_valid_next = adv ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);

        mvalid_next = mvalid_reg;
        if (adv)
        begin
            if (s1_item_reg.new_job)
            begin
                mvalid_next = '0;
            end
            if (s1_range_reg)
            begin
                mvalid_next[s1_addr] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mvalid_reg    <= '0;
            prev_reg      <= '0;
            span_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            mvalid_reg    <= mvalid_next;
            if (adv)
            begin
                prev_reg <= finish_time;
                span_reg <= span_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= step;
            s1_range_reg <= in_range;
            // read-during-write of the same entry returns the old time
            s1_hit_reg   <= adv && s1_range_reg
                            && (step.machine_index == s1_item_reg.machine_index);
        end
        if (adv)
        begin
            res_reg.start_at    <= OUT_BITS'(start_at);
            res_reg.finish_time <= OUT_BITS'(finish_time);
            res_reg.makespan    <= OUT_BITS'(span_next);
            res_reg.last        <= s1_item_reg.job_end;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== tb/sst_timeline_checker.sv =====
module sst_timeline_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_valid,
    input  logic              step_stall,
    input  sst_pkg::sst_in_t  step,
    input  logic              res_valid,
    input  logic              res_stall,
    input  sst_pkg::sst_out_t res,
    output int                fails,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int MACHINES  = MACHINES_DEF;
    localparam int TIME_BITS = TIME_BITS_DEF;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [TIME_BITS-1:0] free_at_time [MACHINES];
    logic                 free_known   [MACHINES];
    logic [TIME_BITS-1:0] last_finish;
    logic [TIME_BITS-1:0] span_so_far;

    sst_out_t step_times_due [$];
    int       reports;

    // start, finish and makespan of one step, advancing the timeline
    function automatic sst_out_t plan_step_times(input sst_in_t s);
        logic [TIME_BITS-1:0] begin_at;
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] end_at;
        sst_out_t             r;
        if (s.new_job)
        begin
            for (int i = 0; i < MACHINES; i++)
                free_known[i] = 1'b0;
            last_finish = '0;
            span_so_far = '0;
        end
        begin_at = '0;
        if (s.machine_index < MACHINES && free_known[s.machine_index])
            begin_at = free_at_time[s.machine_index];
        if (!s.task_start && last_finish > begin_at)
            begin_at = last_finish;
        sum    = {1'b0, begin_at} + (TIME_BITS + 1)'(s.step_length);
        end_at = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_BITS-1:0];
        if (s.machine_index < MACHINES)
        begin
            free_at_time[s.machine_index] = end_at;
            free_known[s.machine_index]   = 1'b1;
        end
        last_finish = end_at;
        if (end_at > span_so_far)
            span_so_far = end_at;
        r.start_at    = OUT_BITS'(begin_at);
        r.finish_time = OUT_BITS'(end_at);
        r.makespan    = OUT_BITS'(span_so_far);
        r.last        = s.job_end;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sst_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MACHINES; i++)
            begin
                free_at_time[i] = '0;
                free_known[i]   = 1'b0;
            end
            last_finish = '0;
            span_so_far = '0;
            step_times_due.delete();
            pending = 0;
            fails   = 0;
            reports = 0;
        end
        else
        begin
            // compare before predicting so a result never meets its own item
            if (res_valid && !res_stall)
            begin
                if (step_times_due.size() == 0)
                begin
                    fails++;
                    if (reports < 10)
                    begin
                        reports++;
                        $display("unexpected result: start %h finish %h span %h last %b",
                                 res.start_at, res.finish_time, res.makespan, res.last);
                    end
                end
                else
                begin
                    want = step_times_due.pop_front();
                    if (res !== want)
                    begin
                        fails++;
                        if (reports < 10)
                        begin
                            reports++;
                            $display("step times mismatch at %0t", $realtime);
                            $display("  start  exp %h got %h", want.start_at, res.start_at);
                            $display("  finish exp %h got %h",
                                     want.finish_time, res.finish_time);
                            $display("  span   exp %h got %h", want.makespan, res.makespan);
                            $display("  last   exp %b got %b", want.last, res.last);
                        end
                    end
                end
            end
            if (step_valid && !step_stall)
                step_times_due.push_back(plan_step_times(step));
            pending = step_times_due.size();
        end
    end

endmodule

// ===== tb/shop_schedule_timeline_top_tb.sv =====
module shop_schedule_timeline_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    // cycles without any handshake before the run is declared hung
    localparam int IDLE_LIMIT = 4000;
    // length of the one long hold-off on the result side
    localparam int HOLD_CYCLES = 300;

    logic     clk;
    logic     rst_n;
    logic     step_valid;
    logic     step_stall;
    sst_in_t  step;
    logic     res_valid;
    logic     res_stall;
    sst_out_t res;

    int fails;
    int pending;
    int burst_left;
    int items_sent;
    int idle_cycles;
    bit want_hold;

    shop_schedule_timeline_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_stall (step_stall),
        .step       (step),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    sst_timeline_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_stall (step_stall),
        .step       (step),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fails      (fails),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // builds one step item from its fields
    function automatic sst_in_t step_item(input bit nj, input bit ts, input bit je,
                                          input logic [MIDX_BITS-1:0] m,
                                          input logic [LEN_BITS-1:0] len);
        sst_in_t s;
        s.new_job       = nj;
        s.task_start    = ts;
        s.job_end       = je;
        s.machine_index = m;
        s.step_length   = len;
        return s;
    endfunction

    // offers one item and waits for its handshake; the sender works in
    // bursts, dropping valid for a random gap only between bursts
    task automatic offer_step(input sst_in_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                step_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        step       <= item;
        step_valid <= 1'b1;
        do
            @(posedge clk);
        while (step_stall);
        burst_left--;
        items_sent++;
    endtask

    // stimulus
    initial
    begin
        int   job_len;
        int   task_left;
        int   pool;
        int   base;
        bit   nj;
        bit   ts;
        logic [LEN_BITS-1:0] len;

        rst_n      <= 1'b0;
        step_valid <= 1'b0;
        step       <= '0;
        burst_left = 0;
        items_sent = 0;
        want_hold  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a step straight after reset with no new job marker
        offer_step(step_item(1'b0, 1'b0, 1'b0, 4'd3, 32'd5));
        offer_step(step_item(1'b0, 1'b0, 1'b0, 4'd3, 32'd0));
        // task start waits only for its machine
        offer_step(step_item(1'b0, 1'b1, 1'b0, 4'd3, 32'd10));
        // new job with the longest step
        offer_step(step_item(1'b1, 1'b1, 1'b0, 4'd0, 32'hFFFF_FFFF));
        offer_step(step_item(1'b0, 1'b0, 1'b0, 4'd15, 32'd1));
        offer_step(step_item(1'b0, 1'b1, 1'b0, 4'd0, 32'd7));
        // machine not yet used in this job reads as free at zero
        offer_step(step_item(1'b0, 1'b1, 1'b0, 4'd5, 32'd0));
        // machine free time beats the previous finish
        offer_step(step_item(1'b0, 1'b0, 1'b0, 4'd0, 32'd3));
        offer_step(step_item(1'b0, 1'b0, 1'b1, 4'd15, 32'd2));
        // later step with no task start at the head of a job
        offer_step(step_item(1'b1, 1'b0, 1'b0, 4'd9, 32'd9));
        offer_step(step_item(1'b0, 1'b0, 1'b0, 4'd9, 32'd0));
        // single-step job
        offer_step(step_item(1'b1, 1'b1, 1'b1, 4'd10, 32'hFFFF_0000));
        offer_step(step_item(1'b1, 1'b1, 1'b0, 4'd15, 32'hFFFF_FFFF));
        offer_step(step_item(1'b0, 1'b0, 1'b0, 4'd15, 32'hFFFF_FFFF));
        offer_step(step_item(1'b0, 1'b0, 1'b0, 4'd15, 32'hFFFF_FFFF));
        offer_step(step_item(1'b0, 1'b0, 1'b1, 4'd15, 32'hAAAA_5555));
        offer_step(step_item(1'b1, 1'b1, 1'b0, 4'd6, 32'h5555_5555));
        offer_step(step_item(1'b0, 1'b1, 1'b0, 4'd6, 32'd0));
        offer_step(step_item(1'b0, 1'b1, 1'b1, 4'd12, 32'd1));

        // random part; the result side holds off once near the start so the
        // pipeline fills and the step channel backs up
        want_hold = 1'b1;
        while (items_sent < 925)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any flags, any machine, any length
                offer_step(step_item(1'($urandom), 1'($urandom), 1'($urandom),
                                     MIDX_BITS'($urandom), $urandom));
            end
            else
            begin
                // well-formed job over a small pool of machines so they collide
                job_len   = $urandom_range(1, 24);
                pool      = $urandom_range(1, 16);
                base      = $urandom_range(0, 15);
                task_left = 0;
                for (int i = 0; i < job_len; i++)
                begin
                    ts = 1'b0;
                    if (task_left == 0)
                    begin
                        task_left = $urandom_range(1, 5);
                        ts = 1'b1;
                    end
                    case ($urandom_range(0, 9))
                        0:       len = '0;
                        1:       len = '1;
                        2:       len = $urandom;
                        3:       len = $urandom_range(0, 15);
                        default: len = $urandom_range(1, 1000);
                    endcase
                    nj = (i == 0);
                    // an occasional broken task boundary
                    if ($urandom_range(0, 15) == 0)
                        ts = ~ts;
                    offer_step(step_item(nj, ts, i == job_len - 1,
                                         MIDX_BITS'((base + $urandom_range(0, pool - 1)) % 16),
                                         len));
                    task_left--;
                end
            end
        end

        // a few closing steps on random machines
        offer_step(step_item(1'b0, 1'b1, 1'b0, MIDX_BITS'($urandom), 32'd0));
        offer_step(step_item(1'b0, 1'b0, 1'b0, MIDX_BITS'($urandom), $urandom));
        offer_step(step_item(1'b0, 1'b1, 1'b1, MIDX_BITS'($urandom), 32'hFFFF_FFFF));

        step_valid <= 1'b0;
        // let the checker count the last item before waiting on the rest
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // keep running so any stray result still shows up
        repeat (8) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side: stall pattern of its own, changing every stretch, plus
    // the one long hold-off that the stimulus asks for
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                if (want_hold && !held)
                begin
                    held = 1'b1;
                    res_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    1:       res_stall <= ($urandom_range(0, 3) == 0);
                    2:       res_stall <= ($urandom_range(0, 3) != 0);
                    3:       res_stall <= ~res_stall;
                    4:       res_stall <= ($urandom_range(0, 1) == 0);
                    default: res_stall <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog: counts cycles with no handshake on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            if ((step_valid && !step_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
